// File: rtl/pipp_pkg.sv
// Shared types, widths and the edge set-up function for the point-in-polygon core.
// Depends on nothing; every other rtl file imports it.
package pipp_pkg;

  // Coordinate width and the widths that follow from it
  localparam int COORD_BITS = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int PROD_W     = 2 * DIFF_W;

  // Edge queue between the front and back parts
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]     diff_t;
  typedef logic signed [PROD_W-1:0]     prod_t;

  // One edge, ready for the cross-product test.
  // live: edge exists and straddles the ray's y; up: edge end b is above end a.
  typedef struct packed {
    logic  live;
    logic  up;
    diff_t dx_ba;
    diff_t dy_pa;
    diff_t dx_pa;
    diff_t dy_ba;
  } edge_t;

  // One queue word: the edge into this vertex and, on a last vertex, the closing edge
  typedef struct packed {
    edge_t main_e;
    edge_t close_e;
    logic  last;
  } qword_t;

  // Straddle test and coordinate differences for edge a->b against point p
  function automatic edge_t make_edge(input coord_t px, input coord_t py,
                                      input coord_t ax, input coord_t ay,
                                      input coord_t bx, input coord_t by,
                                      input logic en);
    edge_t e;
    e.live  = en && ((ay > py) != (by > py));
    e.up    = by > ay;
    e.dx_ba = DIFF_W'(bx) - DIFF_W'(ax);
    e.dy_pa = DIFF_W'(py) - DIFF_W'(ay);
    e.dx_pa = DIFF_W'(px) - DIFF_W'(ax);
    e.dy_ba = DIFF_W'(by) - DIFF_W'(ay);
    return e;
  endfunction

endpackage

// File: rtl/pipp_front.sv
// Front part: accepts vertex words, keeps first and previous vertex, builds edges.
// Depends on pipp_pkg.
module pipp_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            q_full,
  input  pipp_pkg::coord_t point_x,
  input  pipp_pkg::coord_t point_y,
  input  pipp_pkg::coord_t vertex_x,
  input  pipp_pkg::coord_t vertex_y,
  input  logic            last_vertex,
  output logic            in_stall,
  output logic            push,
  output pipp_pkg::qword_t push_word
);
  import pipp_pkg::*;

  coord_t first_vx, first_vy, prev_vx, prev_vy;
  coord_t close_x, close_y;
  logic   started;

  // Accept whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Closing edge runs to the first vertex, or to itself on a one-vertex polygon
  always_comb begin
    close_x = started ? first_vx : vertex_x;
    close_y = started ? first_vy : vertex_y;
    push_word.main_e  = make_edge(point_x, point_y, prev_vx, prev_vy,
                                  vertex_x, vertex_y, started);
    push_word.close_e = make_edge(point_x, point_y, vertex_x, vertex_y,
                                  close_x, close_y, last_vertex);
    push_word.last    = last_vertex;
  end

  // Polygon tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
    end else if (push) begin
      started <= !last_vertex;
    end
  end

  // Vertex store
  always_ff @(posedge clk) begin
    if (push) begin
      prev_vx <= vertex_x;
      prev_vy <= vertex_y;
      if (!started) begin
        first_vx <= vertex_x;
        first_vy <= vertex_y;
      end
    end
  end

  a_last_ends_polygon: assert property (@(posedge clk) disable iff (rst)
    (push && last_vertex) |=> !started)
    else $error("polygon still open after last vertex");

endmodule

// File: rtl/pipp_queue.sv
// Short edge queue between the front and back parts.
// Depends on pipp_pkg.
module pipp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  pipp_pkg::qword_t push_word,
  input  logic             pop,
  output logic             full,
  output logic             empty,
  output pipp_pkg::qword_t head
);
  import pipp_pkg::*;

  qword_t           slots [QDEPTH];
  logic [QAW-1:0]   wr_ptr, rd_ptr;
  logic [QCW-1:0]   count;

  assign full  = count == QCW'(QDEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_word;
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("word pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("word popped from empty queue");

endmodule

// File: rtl/pipp_back.sv
// Back part: cross products, sign tests, crossing parity and the result register.
// Depends on pipp_pkg.
module pipp_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  pipp_pkg::qword_t head,
  output logic             pop,
  input  logic             out_stall,
  output logic             out_valid,
  output logic             inside_res
);
  import pipp_pkg::*;

  logic  adv;
  logic  s1_valid, s1_last;
  logic  m_live, m_up, c_live, c_up;
  prod_t m_pa, m_pb, c_pa, c_pb;
  logic  m_cross, c_cross;
  logic  parity;

  // Whole back part moves unless a result waits on a stalled output
  assign adv = !out_valid || !out_stall;
  assign pop = adv && !q_empty;

  // Product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= !q_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_last <= head.last;
      m_live  <= head.main_e.live;
      m_up    <= head.main_e.up;
      m_pa    <= head.main_e.dx_ba * head.main_e.dy_pa;
      m_pb    <= head.main_e.dx_pa * head.main_e.dy_ba;
      c_live  <= head.close_e.live;
      c_up    <= head.close_e.up;
      c_pa    <= head.close_e.dx_ba * head.close_e.dy_pa;
      c_pb    <= head.close_e.dx_pa * head.close_e.dy_ba;
    end
  end

  // Crossing lies right of the point when the cross product has the edge's sign
  always_comb begin
    m_cross = m_live && (m_up ? (m_pa > m_pb) : (m_pa < m_pb));
    c_cross = c_live && (c_up ? (c_pa > c_pb) : (c_pa < c_pb));
  end

  // Parity and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      parity    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid && s1_last;
      if (s1_valid) begin
        parity <= s1_last ? 1'b0 : (parity ^ m_cross);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid && s1_last) inside_res <= parity ^ m_cross ^ c_cross;
  end

  a_parity_cleared: assert property (@(posedge clk) disable iff (rst)
    (adv && s1_valid && s1_last) |=> !parity)
    else $error("parity not cleared after polygon result");

  a_result_from_last: assert property (@(posedge clk) disable iff (rst)
    (adv && !(s1_valid && s1_last)) |=> !out_valid)
    else $error("result word without a last vertex");

endmodule

// File: rtl/point_in_polygon_parity_core.sv
// Crossing-number point-in-polygon core: one vertex word in, one result per polygon.
// A last vertex passes in turn a queue slot, the product stage and the result register.
// Throughput, when nothing stalls: one vertex per cycle; the back part's product stage
// takes one queue word (the edge into the vertex plus the closing edge) each cycle.
// Reset (rst, synchronous): empties the queue, clears parity and starts a new polygon.
// Depends on pipp_pkg, pipp_front, pipp_queue, pipp_back.
module point_in_polygon_parity_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  pipp_pkg::coord_t point_x,
  input  pipp_pkg::coord_t point_y,
  input  pipp_pkg::coord_t vertex_x,
  input  pipp_pkg::coord_t vertex_y,
  input  logic             last_vertex,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             inside_res
);
  import pipp_pkg::*;

  logic   push, pop, q_full, q_empty;
  qword_t push_word, head;

  // Front: vertex tracking and edge set-up
  pipp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .q_full      (q_full),
    .point_x     (point_x),
    .point_y     (point_y),
    .vertex_x    (vertex_x),
    .vertex_y    (vertex_y),
    .last_vertex (last_vertex),
    .in_stall    (in_stall),
    .push        (push),
    .push_word   (push_word)
  );

  // Edge queue
  pipp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .full      (q_full),
    .empty     (q_empty),
    .head      (head)
  );

  // Back: crossing tests and result
  pipp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .head       (head),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .inside_res (inside_res)
  );

endmodule
